// ===== sv/tsm_pkg.sv =====
`default_nettype none

package tsm_pkg;

    // element width, command width and default list depth
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int DEPTH_DEF = 32;

    // command codes of an input transaction
    localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE         = 2'd2;

    typedef logic [CMD_W-1:0]         command_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_MERGE
    } state_t;

    // controller to datapath
    typedef struct packed
    {
        logic append_first;
        logic append_second;
        logic prime;
        logic step;
    } ctl_t;

    // datapath to controller
    typedef struct packed
    {
        logic lists_empty;
        logic out_free;
        logic last_pick;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/tsm_if.sv =====
`default_nettype none

// input channel: one command with its element
interface tsm_in_if;
    import tsm_pkg::*;

    logic     valid;
    logic     ready;
    command_t command;
    data_t    value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

// output channel: one merged element
interface tsm_out_if;
    import tsm_pkg::*;

    logic  valid;
    logic  ready;
    data_t value_res;
    logic  from_second;
    logic  last;

    modport source (output valid, output value_res, output from_second, output last,
                    input ready);
    modport sink (input valid, input value_res, input from_second, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/tsm_ram.sv =====
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

// ===== sv/tsm_ctrl.sv =====
`default_nettype none

module tsm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               items_valid,
    output logic                    items_ready,
    input  wire tsm_pkg::command_t  command,
    input  wire tsm_pkg::status_t   status,
    output tsm_pkg::ctl_t           ctl
);
    import tsm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (items_valid && command == CMD_MERGE && !status.lists_empty)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (status.out_free && status.last_pick)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        items_ready = 1'b0;
        ctl         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                items_ready = 1'b1;
                if (items_valid)
                begin
                    unique case (command)
                        CMD_APPEND_FIRST:  ctl.append_first  = 1'b1;
                        CMD_APPEND_SECOND: ctl.append_second = 1'b1;
                        CMD_MERGE:         ctl.prime         = 1'b1;
                        default:           ctl               = '0;
                    endcase
                end
            end
            ST_MERGE:
            begin
                ctl.step = status.out_free;
            end
            default:
            begin
                items_ready = 1'b0;
            end
        endcase
    end
endmodule

`default_nettype wire

// ===== sv/tsm_datapath.sv =====
`default_nettype none

module tsm_datapath #(
    parameter int DEPTH = tsm_pkg::DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tsm_pkg::data_t   value,
    input  wire tsm_pkg::ctl_t    ctl,
    output tsm_pkg::status_t      status,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output tsm_pkg::data_t        value_res,
    output logic                  from_second,
    output logic                  last
);
    import tsm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CW-1:0] cnt_first_reg, cnt_first_next;
    logic [CW-1:0] cnt_second_reg, cnt_second_next;
    logic [CW-1:0] idx_first_reg, idx_first_next;
    logic [CW-1:0] idx_second_reg, idx_second_next;
    logic [CW-1:0] idx_first_inc, idx_second_inc;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_res_reg;
    logic              from_second_reg;
    logic              last_reg;

    logic [DATA_W-1:0] head_first, head_second;
    logic              we_first, we_second;
    logic              re_first, re_second;
    logic [AW-1:0]     raddr_first, raddr_second;
    logic              first_has, second_has, pick_first, last_pick, out_free;

    // head selection
    assign idx_first_inc  = idx_first_reg + CW'(1);
    assign idx_second_inc = idx_second_reg + CW'(1);
    assign first_has      = idx_first_reg < cnt_first_reg;
    assign second_has     = idx_second_reg < cnt_second_reg;
    assign pick_first     = first_has &&
                            (!second_has || ($signed(head_first) < $signed(head_second)));
    assign last_pick      = pick_first ? (idx_first_inc == cnt_first_reg && !second_has)
                                       : (idx_second_inc == cnt_second_reg && !first_has);
    assign out_free       = !out_valid_reg || out_ready;

    assign status.lists_empty = (cnt_first_reg == '0) && (cnt_second_reg == '0);
    assign status.out_free    = out_free;
    assign status.last_pick   = last_pick;

    // list memory ports
    assign we_first     = ctl.append_first && (cnt_first_reg < CW'(DEPTH));
    assign we_second    = ctl.append_second && (cnt_second_reg < CW'(DEPTH));
    assign re_first     = ctl.prime || (ctl.step && pick_first);
    assign re_second    = ctl.prime || (ctl.step && !pick_first);
    assign raddr_first  = ctl.step ? idx_first_inc[AW-1:0] : idx_first_reg[AW-1:0];
    assign raddr_second = ctl.step ? idx_second_inc[AW-1:0] : idx_second_reg[AW-1:0];

    tsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_first (
        .clk   (clk),
        .we    (we_first),
        .waddr (cnt_first_reg[AW-1:0]),
        .wdata (value),
        .re    (re_first),
        .raddr (raddr_first),
        .rdata (head_first)
    );

    tsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_second (
        .clk   (clk),
        .we    (we_second),
        .waddr (cnt_second_reg[AW-1:0]),
        .wdata (value),
        .re    (re_second),
        .raddr (raddr_second),
        .rdata (head_second)
    );

    // counts and read indices
    always_comb
    begin
        cnt_first_next  = cnt_first_reg;
        cnt_second_next = cnt_second_reg;
        idx_first_next  = idx_first_reg;
        idx_second_next = idx_second_reg;
        if (we_first)
        begin
            cnt_first_next = cnt_first_reg + CW'(1);
        end
        if (we_second)
        begin
            cnt_second_next = cnt_second_reg + CW'(1);
        end
        if (ctl.step)
        begin
            if (last_pick)
            begin
                cnt_first_next  = '0;
                cnt_second_next = '0;
                idx_first_next  = '0;
                idx_second_next = '0;
            end
            else if (pick_first)
            begin
                idx_first_next = idx_first_inc;
            end
            else
            begin
                idx_second_next = idx_second_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_first_reg  <= '0;
            cnt_second_reg <= '0;
            idx_first_reg  <= '0;
            idx_second_reg <= '0;
        end
        else
        begin
            cnt_first_reg  <= cnt_first_next;
            cnt_second_reg <= cnt_second_next;
            idx_first_reg  <= idx_first_next;
            idx_second_reg <= idx_second_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            value_res_reg   <= pick_first ? head_first : head_second;
            from_second_reg <= !pick_first;
            last_reg        <= last_pick;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_res   = value_res_reg;
    assign from_second = from_second_reg;
    assign last        = last_reg;

    // a new element never overwrites one that is still waiting
    a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (!out_valid_reg || out_ready))
        else $error("merge step while output transaction pending");

    // read indices stay within the filled part of each list
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_first_reg <= cnt_first_reg) && (idx_second_reg <= cnt_second_reg))
        else $error("read index beyond list count");

    // a merge step always has an element to emit
    a_step_has: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (first_has || second_has))
        else $error("merge step with both lists drained");

    // the final element empties both lists
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && last_pick) |=> (cnt_first_reg == '0) && (cnt_second_reg == '0))
        else $error("lists not emptied after final element");

    // counts never exceed the list depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_first_reg <= CW'(DEPTH)) && (cnt_second_reg <= CW'(DEPTH)))
        else $error("list count beyond depth");
endmodule

`default_nettype wire

// ===== sv/two_way_sorted_merge_top.sv =====
`default_nettype none

// channel   dir  handshake       payload
// items     in   valid / ready   command[1:0], value[31:0] signed
// results   out  valid / ready   value_res[31:0] signed, from_second, last
//
// appends are accepted while idle; an append to a full list is dropped
// a merge first fetches both list heads from the list RAMs, then one element
// leaves per cycle through the output register while results is not stalled
// items is not ready while a merge runs; a stall on results holds the merge loop
// rst_n clears the list counts and indices; list contents are not cleared

module two_way_sorted_merge_top #(
    parameter int DEPTH = tsm_pkg::DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tsm_in_if.sink    items,
    tsm_out_if.source results
);
    import tsm_pkg::*;

    ctl_t    ctl;
    status_t status;

    tsm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .items_valid (items.valid),
        .items_ready (items.ready),
        .command     (items.command),
        .status      (status),
        .ctl         (ctl)
    );

    tsm_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (items.value),
        .ctl         (ctl),
        .status      (status),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .value_res   (results.value_res),
        .from_second (results.from_second),
        .last        (results.last)
    );
endmodule

`default_nettype wire
